[rtl/core/pdc_pkg.sv]
`default_nettype none

package pdc_pkg;

    // fixed-point formats
    localparam int FRAC    = 16;
    localparam int W_DATA  = 32;
    localparam int W_GAIN  = 32;
    localparam int W_LIMIT = 31;
    localparam int W_ERR   = W_DATA + 1;
    localparam int W_D1    = W_ERR + 1;
    localparam int W_D2    = W_ERR + 2;
    localparam int W_MUL   = W_GAIN + W_D2;
    localparam int W_PROD  = W_MUL - FRAC;
    localparam int W_INT   = 48;
    localparam int W_ISUM  = W_PROD + 1;
    localparam int W_SUM   = W_PROD + 2;

    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;

    // configuration register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_MODE      = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_OUT_LIMIT = 3'd4;

    // mode codes
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // action codes
    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // 500.0 in Q16.16
    localparam logic [W_LIMIT-1:0] OUT_LIMIT_RESET = 31'd32768000;

    localparam logic signed [W_INT-1:0] INT_MAX = {1'b0, {(W_INT-1){1'b1}}};
    localparam logic signed [W_INT-1:0] INT_MIN = {1'b1, {(W_INT-1){1'b0}}};

    typedef struct packed {
        logic                     mode;
        logic signed [W_GAIN-1:0] gain_p;
        logic signed [W_GAIN-1:0] gain_i;
        logic signed [W_GAIN-1:0] gain_d;
        logic [W_LIMIT-1:0]       out_limit;
    } t_cfg;

    typedef struct packed {
        logic                    action;
        logic signed [W_ERR-1:0] e;
        logic signed [W_D1-1:0]  d1;
        logic signed [W_D2-1:0]  d2;
    } t_err_stage;

    typedef struct packed {
        logic                     action;
        logic signed [W_PROD-1:0] pp;
        logic signed [W_PROD-1:0] pi;
        logic signed [W_PROD-1:0] pd;
    } t_prod_stage;

endpackage

`default_nettype wire

[rtl/core/pdc_if.sv]
`default_nettype none

interface pdc_in_if
    import pdc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [W_DATA-1:0] setpoint;
    logic signed [W_DATA-1:0] measured;

    modport source (output valid, output action, output setpoint, output measured,
                    input ready);
    modport sink   (input valid, input action, input setpoint, input measured,
                    output ready);
endinterface

interface pdc_out_if
    import pdc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [W_DATA-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

[rtl/core/pid_position_delta_controller_unit.sv]
`default_nettype none

// PID controller in signed Q16.16, positional (mode 0) or incremental (mode 1).
// Each word on i_item either runs one control step on setpoint - measured or,
// with action set, clears the error history, the 48-bit integral and the held
// output and returns a drive of zero. One word is taken every cycle unless the
// pipeline is stalled by o_res; each result is registered at the end of every
// stage and offered on o_res from the last, through a three-stage pipeline:
// error and difference terms, which also keep the error history, the three gain
// multiplies, then the integral/output accumulate and clamp. Each stage holds
// its word while the next one stalls, so input keeps flowing into empty stages
// while a result waits on o_res. Products are floored to Q16.16; the drive is
// clamped to plus or minus out_limit. Register writes (0 mode, 1..3 gains P/I/D,
// 4 out_limit) take effect at once and are meant for when no word is in flight;
// other indexes are ignored.
module pid_position_delta_controller_unit
    import pdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_data,
    pdc_in_if.sink                     i_item,
    pdc_out_if.source                  o_res
);

    t_cfg        r_cfg;
    logic        w_err_valid;
    logic        w_err_ready;
    t_err_stage  w_err_stage;
    logic        w_mul_valid;
    logic        w_mul_ready;
    t_prod_stage w_mul_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_POSITIONAL;
            r_cfg.gain_p    <= '0;
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.out_limit <= OUT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:      r_cfg.mode      <= i_cfg_data[0];
                CFG_GAIN_P:    r_cfg.gain_p    <= $signed(i_cfg_data[W_GAIN-1:0]);
                CFG_GAIN_I:    r_cfg.gain_i    <= $signed(i_cfg_data[W_GAIN-1:0]);
                CFG_GAIN_D:    r_cfg.gain_d    <= $signed(i_cfg_data[W_GAIN-1:0]);
                CFG_OUT_LIMIT: r_cfg.out_limit <= i_cfg_data[W_LIMIT-1:0];
                default: begin
                end
            endcase
        end
    end

    pdc_err u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_item.valid),
        .o_ready    (i_item.ready),
        .i_action   (i_item.action),
        .i_setpoint (i_item.setpoint),
        .i_measured (i_item.measured),
        .o_valid    (w_err_valid),
        .i_ready    (w_err_ready),
        .o_stage    (w_err_stage)
    );

    pdc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_err_valid),
        .o_ready (w_err_ready),
        .i_stage (w_err_stage),
        .o_valid (w_mul_valid),
        .i_ready (w_mul_ready),
        .o_stage (w_mul_stage)
    );

    pdc_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_mul_valid),
        .o_ready (w_mul_ready),
        .i_stage (w_mul_stage),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_drive (o_res.drive)
    );

endmodule

`default_nettype wire

[rtl/core/pdc_err.sv]
`default_nettype none

module pdc_err
    import pdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_action,
    input  wire logic signed [W_DATA-1:0] i_setpoint,
    input  wire logic signed [W_DATA-1:0] i_measured,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output t_err_stage                    o_stage
);

    logic                    r_valid;
    t_err_stage              r_stage;
    logic signed [W_ERR-1:0] r_e1;
    logic signed [W_ERR-1:0] r_e2;
    logic signed [W_ERR-1:0] n_e;
    t_err_stage              n_stage;
    logic                    w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_stage  = r_stage;

    always_comb begin
        n_e = $signed({i_setpoint[W_DATA-1], i_setpoint})
            - $signed({i_measured[W_DATA-1], i_measured});
        n_stage.action = i_action;
        n_stage.e      = n_e;
        n_stage.d1     = $signed({n_e[W_ERR-1], n_e}) - $signed({r_e1[W_ERR-1], r_e1});
        // e - 2*e1 + e2
        n_stage.d2     = $signed({{2{n_e[W_ERR-1]}}, n_e})
                       - $signed({r_e1[W_ERR-1], r_e1, 1'b0})
                       + $signed({{2{r_e2[W_ERR-1]}}, r_e2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_e1    <= '0;
            r_e2    <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_accept) begin
                if (i_action == ACT_CLEAR) begin
                    r_e1 <= '0;
                    r_e2 <= '0;
                end else begin
                    r_e1 <= n_e;
                    r_e2 <= r_e1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage <= n_stage;
        end
    end

    a_clear_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_CLEAR) |=> (r_e1 == '0 && r_e2 == '0))
        else $error("error history not cleared");

endmodule

`default_nettype wire

[rtl/core/pdc_mul.sv]
`default_nettype none

module pdc_mul
    import pdc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_err_stage i_stage,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_prod_stage     o_stage
);

    logic                    r_valid;
    t_prod_stage             r_stage;
    t_prod_stage             n_stage;
    logic signed [W_D2-1:0]  w_op_p;
    logic signed [W_D2-1:0]  w_op_i;
    logic signed [W_D2-1:0]  w_op_d;
    logic signed [W_D2-1:0]  w_e_ext;
    logic signed [W_D2-1:0]  w_d1_ext;
    logic signed [W_MUL-1:0] w_prod_p;
    logic signed [W_MUL-1:0] w_prod_i;
    logic signed [W_MUL-1:0] w_prod_d;
    logic                    w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_stage  = r_stage;

    always_comb begin
        w_e_ext  = $signed({{(W_D2-W_ERR){i_stage.e[W_ERR-1]}}, i_stage.e});
        w_d1_ext = $signed({{(W_D2-W_D1){i_stage.d1[W_D1-1]}}, i_stage.d1});
        w_op_i   = w_e_ext;
        if (i_cfg.mode == MODE_INCREMENTAL) begin
            w_op_p = w_d1_ext;
            w_op_d = $signed(i_stage.d2);
        end else begin
            w_op_p = w_e_ext;
            w_op_d = w_d1_ext;
        end
        w_prod_p = $signed(i_cfg.gain_p) * w_op_p;
        w_prod_i = $signed(i_cfg.gain_i) * w_op_i;
        w_prod_d = $signed(i_cfg.gain_d) * w_op_d;
        // dropping the fraction bits floors toward minus infinity
        n_stage.action = i_stage.action;
        n_stage.pp     = w_prod_p[W_MUL-1:FRAC];
        n_stage.pi     = w_prod_i[W_MUL-1:FRAC];
        n_stage.pd     = w_prod_d[W_MUL-1:FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage <= n_stage;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pdc_acc.sv]
`default_nettype none

module pdc_acc
    import pdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_prod_stage i_stage,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [W_DATA-1:0] o_drive
);

    logic                     r_valid;
    logic signed [W_INT-1:0]  r_integral;
    logic signed [W_DATA-1:0] r_held;
    logic signed [W_ISUM-1:0] w_isum;
    logic signed [W_INT-1:0]  n_integral;
    logic signed [W_SUM-1:0]  w_next;
    logic signed [W_SUM-1:0]  w_lim;
    logic signed [W_SUM-1:0]  w_clamped;
    logic signed [W_DATA-1:0] n_held;
    logic                     w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_drive  = r_held;

    always_comb begin
        w_isum = $signed({{(W_ISUM-W_INT){r_integral[W_INT-1]}}, r_integral})
               + $signed({{(W_ISUM-W_PROD){i_stage.pi[W_PROD-1]}}, i_stage.pi});
        // saturate the running sum to 48 bits
        if ((&w_isum[W_ISUM-1:W_INT-1]) || !(|w_isum[W_ISUM-1:W_INT-1])) begin
            n_integral = w_isum[W_INT-1:0];
        end else if (w_isum[W_ISUM-1]) begin
            n_integral = INT_MIN;
        end else begin
            n_integral = INT_MAX;
        end

        if (i_cfg.mode == MODE_INCREMENTAL) begin
            w_next = $signed({{(W_SUM-W_DATA){r_held[W_DATA-1]}}, r_held})
                   + $signed({{(W_SUM-W_PROD){i_stage.pp[W_PROD-1]}}, i_stage.pp})
                   + $signed({{(W_SUM-W_PROD){i_stage.pi[W_PROD-1]}}, i_stage.pi})
                   + $signed({{(W_SUM-W_PROD){i_stage.pd[W_PROD-1]}}, i_stage.pd});
        end else begin
            w_next = $signed({{(W_SUM-W_PROD){i_stage.pp[W_PROD-1]}}, i_stage.pp})
                   + $signed({{(W_SUM-W_INT){n_integral[W_INT-1]}}, n_integral})
                   + $signed({{(W_SUM-W_PROD){i_stage.pd[W_PROD-1]}}, i_stage.pd});
        end

        w_lim = $signed({{(W_SUM-W_LIMIT){1'b0}}, i_cfg.out_limit});
        if (w_next > w_lim) begin
            w_clamped = w_lim;
        end else if (w_next < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = w_next;
        end
        n_held = w_clamped[W_DATA-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_integral <= '0;
            r_held     <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_accept) begin
                if (i_stage.action == ACT_CLEAR) begin
                    r_integral <= '0;
                    r_held     <= '0;
                end else begin
                    if (i_cfg.mode == MODE_POSITIONAL) begin
                        r_integral <= n_integral;
                    end
                    r_held <= n_held;
                end
            end
        end
    end

    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($signed({r_held[W_DATA-1], r_held}) <= $signed({2'b00, i_cfg.out_limit})
                  && $signed({r_held[W_DATA-1], r_held}) >= -$signed({2'b00, i_cfg.out_limit})))
        else $error("drive outside the output limit");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_stage.action == ACT_CLEAR) |=> (r_valid && r_held == '0 && r_integral == '0))
        else $error("clear did not zero the output and integral");

    a_incr_keeps_integral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_stage.action == ACT_STEP && i_cfg.mode == MODE_INCREMENTAL)
        |=> $stable(r_integral))
        else $error("integral changed in incremental mode");

endmodule

`default_nettype wire
